// ----- hdl/bearing_factor_jacobian_top_macros.svh -----
// Assertion helpers shared by the bearing factor Jacobian RTL.
`ifndef BEARING_FACTOR_JACOBIAN_TOP_MACROS_SVH
`define BEARING_FACTOR_JACOBIAN_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BFJ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define BFJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bfj_pkg.sv -----
package bfj_pkg;

    localparam int ROWS   = 3;
    localparam int ACC_W  = 52;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;

    // register indexes
    localparam logic CFG_WEIGHT   = 1'b0;
    localparam logic CFG_MIN_DIST = 1'b1;

    localparam logic [30:0] WEIGHT_RESET   = 31'd65536;
    localparam logic [30:0] MIN_DIST_RESET = 31'd66;
    localparam logic [30:0] SAT31_MAX      = 31'h7FFFFFFF;

    localparam logic [1:0] ROW_LAST   = 2'd2;
    localparam logic [1:0] ROW_UNUSED = 2'd3;

    localparam logic signed [ACC_W-1:0] Q30_ONE = 52'sd1073741824;
    localparam logic signed [ACC_W-1:0] S32_MAX = 52'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN = -52'sd2147483648;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] rot_col0;
        logic signed [31:0] rot_col1;
        logic signed [31:0] rot_col2;
        logic signed [31:0] camera_pos;
        logic signed [31:0] landmark_pos;
        logic               pose_fixed;
        logic               landmark_fixed;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         out_row;
        logic               last;
        logic               too_close;
        logic signed [31:0] pose_trans0;
        logic signed [31:0] pose_trans1;
        logic signed [31:0] pose_trans2;
        logic signed [31:0] pose_rot0;
        logic signed [31:0] pose_rot1;
        logic signed [31:0] pose_rot2;
        logic signed [31:0] land_col0;
        logic signed [31:0] land_col1;
        logic signed [31:0] land_col2;
    } t_out_word;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_PMUL = 13'b0000000000010,
        ST_NSQ  = 13'b0000000000100,
        ST_SQRT = 13'b0000000001000,
        ST_CHK  = 13'b0000000010000,
        ST_BSET = 13'b0000000100000,
        ST_DIV  = 13'b0000001000000,
        ST_SSET = 13'b0000010000000,
        ST_QMUL = 13'b0000100000000,
        ST_DMUL = 13'b0001000000000,
        ST_JMUL = 13'b0010000000000,
        ST_OUT  = 13'b0100000000000,
        ST_ERR  = 13'b1000000000000
    } t_state;

    function automatic logic signed [31:0] f_sat32(input logic signed [ACC_W-1:0] x);
        if (x > S32_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (x < S32_MIN) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // round half up, drop 16 fraction bits
    function automatic logic signed [ACC_W-1:0] f_rnd16(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + 66'sd32768;
        return {{2{t[PROD_W-1]}}, t[PROD_W-1:16]};
    endfunction

    // round half up, drop 30 fraction bits
    function automatic logic signed [ACC_W-1:0] f_rnd30(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + 66'sd536870912;
        return {{16{t[PROD_W-1]}}, t[PROD_W-1:30]};
    endfunction

    // flat index of a 3x3 entry
    function automatic logic [3:0] f_idx(input logic [1:0] r, input logic [1:0] c);
        logic [3:0] t;
        t = {2'b00, r};
        return (t << 1) + t + {2'b00, c};
    endfunction

endpackage

// ----- hdl/bearing_factor_jacobian_top.sv -----
// Rows 0 and 1 are stored while idle; a row 2 word starts a run that gives
// three result rows in order, each held until the output takes it.
// A too-close run gives a single result word instead.
// The run time is set by one shared 33x33 multiplier (load a, load b, multiply, consume),
// a one-bit-per-cycle square root (32 steps) and a restoring divider (64 steps).
// Reset (i_rst_n low, synchronous) idles the sequencer, drops the output
// and loads register defaults.
`include "bearing_factor_jacobian_top_macros.svh"

module bearing_factor_jacobian_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bfj_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bfj_pkg::t_out_word   o_out_word,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [30:0]          i_cfg_data
);

    bfj_pkg::t_state r_state;
    logic [1:0]  r_i, r_j, r_k, r_ph;
    logic        r_half, r_dsel;
    logic [30:0] r_weight, r_min;
    logic [1:0]  r_flags;

    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_cam [3];
    logic signed [31:0] r_lnd [3];
    logic signed [31:0] r_p   [3];
    logic signed [31:0] r_b   [3];
    logic signed [31:0] r_dm  [9];
    logic signed [31:0] r_jl  [3];
    logic signed [31:0] r_jt  [3];
    logic signed [31:0] r_jr  [3];

    logic signed [bfj_pkg::MUL_W-1:0]  r_ma, r_mb;
    logic signed [bfj_pkg::PROD_W-1:0] r_prod;
    logic signed [bfj_pkg::ACC_W-1:0]  r_acc;
    logic [63:0] r_n2;
    logic [63:0] r_sx, r_sr, r_bit;
    logic [31:0] r_n;
    logic [30:0] r_sc;
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;

    bfj_pkg::t_out_word r_out;
    logic               r_ovalid;

    logic in_take, out_free, out_load;
    logic [3:0] idx_ij, idx_ik, idx_kj, rot_addr, dm_addr;
    logic [1:0] p_addr, b_addr, sk_idx;
    logic sk_neg, sk_zero;
    logic signed [31:0] rot_rd, p_rd, b_rd, dm_rd;
    logic signed [32:0] diff, sk_val, p_ext;
    logic signed [31:0] d_sat;
    logic signed [bfj_pkg::MUL_W-1:0] ma_sel, mb_sel;
    logic signed [bfj_pkg::ACC_W-1:0] t16, t30, acc_sum, q_full;
    logic first_term;
    logic [63:0] n2_new;
    logic [63:0] sq_sum, sq_nsx, sq_nsr;
    logic        sq_ge;
    logic [32:0] rem_sh;
    logic        dv_ge;
    logic [31:0] dv_rem;
    logic [63:0] dv_num, b_num, s_num;
    logic [32:0] p_mag;
    logic signed [31:0] b_res;
    logic [30:0] s_res;
    bfj_pkg::t_out_word err_word, row_word;

    assign o_in_stall  = (r_state != bfj_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign out_load = out_free &&
                      (r_state == bfj_pkg::ST_OUT || r_state == bfj_pkg::ST_ERR);

    // one read address per store
    always_comb begin
        idx_ij   = bfj_pkg::f_idx(r_i, r_j);
        idx_ik   = bfj_pkg::f_idx(r_i, r_k);
        idx_kj   = bfj_pkg::f_idx(r_k, r_j);
        rot_addr = (r_state == bfj_pkg::ST_PMUL) ? idx_ij : idx_kj;
        dm_addr  = (r_state == bfj_pkg::ST_JMUL) ? idx_ik : idx_ij;
        b_addr   = (r_ph == 2'd0) ? r_i : r_j;
        unique case ({r_k, r_j})
            4'b0001: begin sk_idx = 2'd2; sk_neg = 1'b0; sk_zero = 1'b0; end
            4'b0010: begin sk_idx = 2'd1; sk_neg = 1'b1; sk_zero = 1'b0; end
            4'b0100: begin sk_idx = 2'd2; sk_neg = 1'b1; sk_zero = 1'b0; end
            4'b0110: begin sk_idx = 2'd0; sk_neg = 1'b0; sk_zero = 1'b0; end
            4'b1000: begin sk_idx = 2'd1; sk_neg = 1'b0; sk_zero = 1'b0; end
            4'b1001: begin sk_idx = 2'd0; sk_neg = 1'b1; sk_zero = 1'b0; end
            default: begin sk_idx = 2'd0; sk_neg = 1'b0; sk_zero = 1'b1; end
        endcase
        p_addr = (r_state == bfj_pkg::ST_JMUL) ? sk_idx : r_i;
        rot_rd = r_rot[rot_addr];
        p_rd   = r_p[p_addr];
        b_rd   = r_b[b_addr];
        dm_rd  = r_dm[dm_addr];
        p_ext  = {p_rd[31], p_rd};
        sk_val = sk_zero ? 33'sd0 : (sk_neg ? -p_ext : p_ext);
        diff   = {r_lnd[r_j][31], r_lnd[r_j]} - {r_cam[r_j][31], r_cam[r_j]};
        d_sat  = bfj_pkg::f_sat32({{19{diff[32]}}, diff});
    end

    // multiplier operand select
    always_comb begin
        unique case (r_state)
            bfj_pkg::ST_PMUL: begin
                ma_sel = {rot_rd[31], rot_rd};
                mb_sel = {d_sat[31], d_sat};
            end
            bfj_pkg::ST_NSQ: begin
                ma_sel = p_ext;
                mb_sel = p_ext;
            end
            bfj_pkg::ST_QMUL: begin
                ma_sel = {b_rd[31], b_rd};
                mb_sel = {b_rd[31], b_rd};
            end
            bfj_pkg::ST_DMUL: begin
                ma_sel = {dm_rd[31], dm_rd};
                mb_sel = {2'b00, r_sc};
            end
            bfj_pkg::ST_JMUL: begin
                ma_sel = {dm_rd[31], dm_rd};
                mb_sel = r_half ? sk_val : {rot_rd[31], rot_rd};
            end
            default: begin
                ma_sel = '0;
                mb_sel = '0;
            end
        endcase
    end

    // product consumers
    always_comb begin
        t16        = bfj_pkg::f_rnd16(r_prod);
        t30        = bfj_pkg::f_rnd30(r_prod);
        first_term = (r_state == bfj_pkg::ST_PMUL) ? (r_j == 2'd0) : (r_k == 2'd0);
        acc_sum    = (first_term ? '0 : r_acc) + t16;
        q_full     = ((r_i == r_j) ? bfj_pkg::Q30_ONE : '0) - t30;
        n2_new     = ((r_i == 2'd0) ? 64'd0 : r_n2) + r_prod[63:0];
    end

    // square root step
    always_comb begin
        sq_sum = r_sr + r_bit;
        sq_ge  = (r_sx >= sq_sum);
        sq_nsx = sq_ge ? (r_sx - sq_sum) : r_sx;
        sq_nsr = sq_ge ? ((r_sr >> 1) + r_bit) : (r_sr >> 1);
    end

    // divider step and operand setup
    always_comb begin
        rem_sh = {r_rem, r_num[63]};
        dv_ge  = (rem_sh >= {1'b0, r_n});
        dv_rem = dv_ge ? 32'(rem_sh - {1'b0, r_n}) : rem_sh[31:0];
        dv_num = {r_num[62:0], dv_ge};
        p_mag  = p_rd[31] ? -p_ext : p_ext;
        b_num  = ({31'd0, p_mag} << 30) + {33'd0, r_n[31:1]};
        s_num  = ({33'd0, r_weight} << 16) + {33'd0, r_n[31:1]};
        b_res  = p_rd[31] ? -dv_num[31:0] : dv_num[31:0];
        s_res  = (dv_num > {33'd0, bfj_pkg::SAT31_MAX}) ? bfj_pkg::SAT31_MAX : dv_num[30:0];
    end

    // result words
    always_comb begin
        err_word           = '0;
        err_word.last      = 1'b1;
        err_word.too_close = 1'b1;
        row_word.out_row     = r_i;
        row_word.last        = (r_i == bfj_pkg::ROW_LAST);
        row_word.too_close   = 1'b0;
        row_word.pose_trans0 = r_flags[0] ? 32'sd0 : r_jt[0];
        row_word.pose_trans1 = r_flags[0] ? 32'sd0 : r_jt[1];
        row_word.pose_trans2 = r_flags[0] ? 32'sd0 : r_jt[2];
        row_word.pose_rot0   = r_flags[0] ? 32'sd0 : r_jr[0];
        row_word.pose_rot1   = r_flags[0] ? 32'sd0 : r_jr[1];
        row_word.pose_rot2   = r_flags[0] ? 32'sd0 : r_jr[2];
        row_word.land_col0   = r_flags[1] ? 32'sd0 : r_jl[0];
        row_word.land_col1   = r_flags[1] ? 32'sd0 : r_jl[1];
        row_word.land_col2   = r_flags[1] ? 32'sd0 : r_jl[2];
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfj_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_flags  <= 2'b00;
            r_weight <= bfj_pkg::WEIGHT_RESET;
            r_min    <= bfj_pkg::MIN_DIST_RESET;
            r_i      <= 2'd0;
            r_j      <= 2'd0;
            r_k      <= 2'd0;
            r_ph     <= 2'd0;
            r_half   <= 1'b0;
            r_dsel   <= 1'b0;
            r_cnt    <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bfj_pkg::CFG_WEIGHT:   r_weight <= i_cfg_data;
                    bfj_pkg::CFG_MIN_DIST: r_min    <= i_cfg_data;
                endcase
            end

            // output word handshake
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            // four phases per product: load a, load b, multiply, consume
            if (r_state == bfj_pkg::ST_PMUL || r_state == bfj_pkg::ST_NSQ ||
                r_state == bfj_pkg::ST_QMUL || r_state == bfj_pkg::ST_DMUL ||
                r_state == bfj_pkg::ST_JMUL) begin
                r_ph <= r_ph + 2'd1;
                unique case (r_ph)
                    2'd0: r_ma   <= ma_sel;
                    2'd1: r_mb   <= mb_sel;
                    2'd2: r_prod <= r_ma * r_mb;
                    2'd3: ;
                endcase
            end

            unique case (r_state)
                bfj_pkg::ST_IDLE: begin
                    if (in_take && i_in_word.row_index != bfj_pkg::ROW_UNUSED) begin
                        r_rot[bfj_pkg::f_idx(i_in_word.row_index, 2'd0)] <= i_in_word.rot_col0;
                        r_rot[bfj_pkg::f_idx(i_in_word.row_index, 2'd1)] <= i_in_word.rot_col1;
                        r_rot[bfj_pkg::f_idx(i_in_word.row_index, 2'd2)] <= i_in_word.rot_col2;
                        r_cam[i_in_word.row_index] <= i_in_word.camera_pos;
                        r_lnd[i_in_word.row_index] <= i_in_word.landmark_pos;
                        r_flags <= {i_in_word.landmark_fixed, i_in_word.pose_fixed};
                        if (i_in_word.row_index == bfj_pkg::ROW_LAST) begin
                            r_state <= bfj_pkg::ST_PMUL;
                            r_i     <= 2'd0;
                            r_j     <= 2'd0;
                        end
                    end
                end
                // p = R(L-P)
                bfj_pkg::ST_PMUL: begin
                    if (r_ph == 2'd3) begin
                        r_acc <= acc_sum;
                        if (r_j == 2'd2) begin
                            r_p[r_i] <= bfj_pkg::f_sat32(acc_sum);
                            r_j      <= 2'd0;
                            if (r_i == 2'd2) begin
                                r_i     <= 2'd0;
                                r_state <= bfj_pkg::ST_NSQ;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                // squared norm
                bfj_pkg::ST_NSQ: begin
                    if (r_ph == 2'd3) begin
                        r_n2 <= n2_new;
                        if (r_i == 2'd2) begin
                            r_sx    <= n2_new;
                            r_sr    <= 64'd0;
                            r_bit   <= 64'h4000000000000000;
                            r_state <= bfj_pkg::ST_SQRT;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                bfj_pkg::ST_SQRT: begin
                    r_sx  <= sq_nsx;
                    r_sr  <= sq_nsr;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_n     <= sq_nsr[31:0];
                        r_state <= bfj_pkg::ST_CHK;
                    end
                end
                bfj_pkg::ST_CHK: begin
                    r_i <= 2'd0;
                    if (r_n == 32'd0 || r_n < {1'b0, r_min}) begin
                        r_state <= bfj_pkg::ST_ERR;
                    end else begin
                        r_state <= bfj_pkg::ST_BSET;
                    end
                end
                bfj_pkg::ST_ERR: begin
                    if (out_free) begin
                        r_out   <= err_word;
                        r_state <= bfj_pkg::ST_IDLE;
                    end
                end
                bfj_pkg::ST_BSET: begin
                    r_num   <= b_num;
                    r_rem   <= 32'd0;
                    r_cnt   <= 6'd0;
                    r_dsel  <= 1'b0;
                    r_state <= bfj_pkg::ST_DIV;
                end
                bfj_pkg::ST_SSET: begin
                    r_num   <= s_num;
                    r_rem   <= 32'd0;
                    r_cnt   <= 6'd0;
                    r_dsel  <= 1'b1;
                    r_state <= bfj_pkg::ST_DIV;
                end
                // shared restoring divider, one quotient bit per cycle
                bfj_pkg::ST_DIV: begin
                    r_num <= dv_num;
                    r_rem <= dv_rem;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        if (!r_dsel) begin
                            r_b[r_i] <= b_res;
                            if (r_i == 2'd2) begin
                                r_state <= bfj_pkg::ST_SSET;
                            end else begin
                                r_i     <= r_i + 2'd1;
                                r_state <= bfj_pkg::ST_BSET;
                            end
                        end else begin
                            r_sc    <= s_res;
                            r_i     <= 2'd0;
                            r_j     <= 2'd0;
                            r_state <= bfj_pkg::ST_QMUL;
                        end
                    end
                end
                // Q = I - b b^T
                bfj_pkg::ST_QMUL: begin
                    if (r_ph == 2'd3) begin
                        r_dm[idx_ij] <= q_full[31:0];
                        if (r_j == 2'd2) begin
                            r_j <= 2'd0;
                            if (r_i == 2'd2) begin
                                r_i     <= 2'd0;
                                r_state <= bfj_pkg::ST_DMUL;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                // D = Q * s, in place
                bfj_pkg::ST_DMUL: begin
                    if (r_ph == 2'd3) begin
                        r_dm[idx_ij] <= bfj_pkg::f_sat32(t30);
                        if (r_j == 2'd2) begin
                            r_j <= 2'd0;
                            if (r_i == 2'd2) begin
                                r_i     <= 2'd0;
                                r_k     <= 2'd0;
                                r_half  <= 1'b0;
                                r_state <= bfj_pkg::ST_JMUL;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                // one Jacobian row: D R, then D(-skew(p))
                bfj_pkg::ST_JMUL: begin
                    if (r_ph == 2'd3) begin
                        r_acc <= acc_sum;
                        if (r_k == 2'd2) begin
                            r_k <= 2'd0;
                            if (!r_half) begin
                                r_jl[r_j] <= bfj_pkg::f_sat32(acc_sum);
                                r_jt[r_j] <= bfj_pkg::f_sat32(-acc_sum);
                                r_half    <= 1'b1;
                            end else begin
                                r_jr[r_j] <= bfj_pkg::f_sat32(acc_sum);
                                r_half    <= 1'b0;
                                if (r_j == 2'd2) begin
                                    r_j     <= 2'd0;
                                    r_state <= bfj_pkg::ST_OUT;
                                end else begin
                                    r_j <= r_j + 2'd1;
                                end
                            end
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                bfj_pkg::ST_OUT: begin
                    if (out_free) begin
                        r_out <= row_word;
                        if (r_i == bfj_pkg::ROW_LAST) begin
                            r_i     <= 2'd0;
                            r_state <= bfj_pkg::ST_IDLE;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= bfj_pkg::ST_JMUL;
                        end
                    end
                end
                default: r_state <= bfj_pkg::ST_IDLE;
            endcase
        end
    end

    // checks
    `BFJ_ASSERT_NEXT(a_run_start, i_clk, i_rst_n, in_take && i_in_word.row_index == bfj_pkg::ROW_LAST, r_state == bfj_pkg::ST_PMUL, "row 2 word did not start a run")
    `BFJ_ASSERT_IMPL(a_div_rem, i_clk, i_rst_n, r_state == bfj_pkg::ST_DIV, r_rem < r_n, "divider remainder not below divisor")
    `BFJ_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, r_ovalid && r_out.too_close, r_out.last && r_out.out_row == 2'd0, "error word not a single last word")
    `BFJ_ASSERT_IMPL(a_last_row, i_clk, i_rst_n, r_ovalid && r_out.last && !r_out.too_close, r_out.out_row == bfj_pkg::ROW_LAST, "last flag on wrong row")

endmodule
